/* rtl/color_ramp_texture_generator_unit_assert.svh */
// Assertion macros for the color ramp texture generator.
`ifndef COLOR_RAMP_TEXTURE_GENERATOR_UNIT_ASSERT_SVH
`define COLOR_RAMP_TEXTURE_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CRTG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crtg: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CRTG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crtg: next-cycle check failed");

`endif

/* rtl/crtg_pkg.sv */
// Shared widths, constants and status codes of the color ramp texture generator.
package crtg_pkg;

    localparam int COLOR_W       = 16;
    localparam int POS_W         = 17;
    localparam int POS_FRAC_W    = 16;
    localparam int TEXEL_IDX_W   = 6;
    localparam int STATUS_W      = 3;
    localparam int TSIZE_W       = 7;
    localparam int NUM_CH        = 4;
    localparam int NUM_ERR       = 5;
    localparam int MAX_TEXELS_DEF = 64;

    localparam logic [POS_W-1:0]   POS_ONE     = 17'h10000;
    localparam logic [TSIZE_W-1:0] TSIZE_RESET = 7'd64;

    typedef logic [COLOR_W-1:0]  color_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK             = 3'd0;
    localparam status_t ST_FIRST_NOT_ZERO = 3'd1;
    localparam status_t ST_NOT_INCREASING = 3'd2;
    localparam status_t ST_LAST_NOT_ONE   = 3'd3;
    localparam status_t ST_TOO_FEW        = 3'd4;
    localparam status_t ST_NO_RAMP        = 3'd5;

endpackage

/* rtl/crtg_node_if.sv */
// Node channel: one transfer-function node per word.
interface crtg_node_if;
    logic                         valid;
    logic                         ready;
    logic [crtg_pkg::COLOR_W-1:0] red;
    logic [crtg_pkg::COLOR_W-1:0] green;
    logic [crtg_pkg::COLOR_W-1:0] blue;
    logic [crtg_pkg::COLOR_W-1:0] opacity;
    logic [crtg_pkg::POS_W-1:0]   position;
    logic                         first_node;
    logic                         last_node;

    modport source
    (
        output valid, red, green, blue, opacity, position, first_node, last_node,
        input  ready
    );

    modport sink
    (
        input  valid, red, green, blue, opacity, position, first_node, last_node,
        output ready
    );
endinterface

/* rtl/crtg_texel_if.sv */
// Texel channel: one texel or one error report per word.
interface crtg_texel_if;
    logic                             valid;
    logic                             ready;
    logic [crtg_pkg::TEXEL_IDX_W-1:0] texel_index;
    logic [crtg_pkg::COLOR_W-1:0]     texel_red;
    logic [crtg_pkg::COLOR_W-1:0]     texel_green;
    logic [crtg_pkg::COLOR_W-1:0]     texel_blue;
    logic [crtg_pkg::COLOR_W-1:0]     texel_opacity;
    logic                             end_of_run;
    logic [crtg_pkg::STATUS_W-1:0]    status;

    modport source
    (
        output valid, texel_index, texel_red, texel_green, texel_blue, texel_opacity,
               end_of_run, status,
        input  ready
    );

    modport sink
    (
        input  valid, texel_index, texel_red, texel_green, texel_blue, texel_opacity,
               end_of_run, status,
        output ready
    );
endinterface

/* rtl/color_ramp_texture_generator_unit.sv */
// Top level of the color ramp texture generator: node checks, divider, texel stepper.
//
// Builds a piecewise-linear RGBA ramp from nodes taken one word at a time on
// the node channel. A first node opens a ramp and produces nothing; every later
// node produces the texels from the previous texel index up to its own index
// p2 = floor(position * (size - 1) / 2^16), inclusive, each channel being
// (c1*(L-k) + c2*k) / L truncated, or the new color when the run length L is 0.
// Rule violations come out as error words (status 1..5, index and color 0),
// one per broken rule in increasing code order, and close the ramp. The last
// word of each node has end_of_run set. After an error or segment node the
// node channel is held off until the node is done; a good first node leaves
// it ready. An error node sends one word per broken rule; a segment node
// passes a setup state, then the shared radix-2 restoring divider when L > 0
// (16 quotient bits for each of the four color channels, one bit a cycle: it
// forms the per-texel step (c2-c1)/L as quotient and remainder), then texel
// output, one texel a cycle while the output slot is free, from an add/compare
// stepper. Output back-pressure stretches the output phases cycle for cycle;
// an output register lets a node be taken while the last word still waits.
// texture_size (cfg_we/cfg_wdata) must be written only while idle; the block
// itself does not enforce this. 0 is used as 1 and values above MAX_TEXELS
// as MAX_TEXELS.
module color_ramp_texture_generator_unit
#(
    parameter int MAX_TEXELS = crtg_pkg::MAX_TEXELS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    crtg_node_if.sink                    node,
    crtg_texel_if.source                 texel,
    input  logic                         cfg_we,
    input  logic [crtg_pkg::TSIZE_W-1:0] cfg_wdata
);

    localparam int IDX_W     = $clog2(MAX_TEXELS);
    localparam int TS_W      = $clog2(MAX_TEXELS + 1);
    localparam int CW        = crtg_pkg::COLOR_W;
    localparam int PW        = crtg_pkg::POS_W;
    localparam int QW        = CW + 2;
    localparam int BIT_W     = $clog2(CW);
    localparam int NCH       = crtg_pkg::NUM_CH;
    localparam int CH_W      = $clog2(NCH);
    localparam int NERR      = crtg_pkg::NUM_ERR;
    localparam int OUT_IDX_W = crtg_pkg::TEXEL_IDX_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_RUN   = 3'd3;
    localparam logic [2:0] S_ERR   = 3'd4;

    // ---------------------------------------------------------------- state
    logic [2:0]               state_reg,        state_next;
    logic [crtg_pkg::TSIZE_W-1:0] texture_size_reg;
    logic                     ramp_open_reg,    ramp_open_next;
    logic [NERR-1:0]          err_mask_reg,     err_mask_next;

    // previous node (c1) and pending node (c2)
    crtg_pkg::color_t         prev_col_reg [NCH];
    crtg_pkg::color_t         prev_col_next [NCH];
    logic [PW-1:0]            prev_pos_reg,     prev_pos_next;
    logic [IDX_W-1:0]         prev_texel_reg,   prev_texel_next;
    crtg_pkg::color_t         new_col_reg [NCH];
    crtg_pkg::color_t         new_col_next [NCH];
    logic [PW-1:0]            new_pos_reg,      new_pos_next;
    logic                     new_last_reg,     new_last_next;

    // run geometry
    logic [IDX_W-1:0]         p1_reg,           p1_next;
    logic [IDX_W-1:0]         p2_reg,           p2_next;
    logic [IDX_W-1:0]         len_reg,          len_next;
    logic [IDX_W-1:0]         k_reg,            k_next;

    // shared divider
    logic [CH_W-1:0]          ch_reg,           ch_next;
    logic [BIT_W-1:0]         bit_reg,          bit_next;
    logic [CW-1:0]            dvd_reg,          dvd_next;
    logic [CW-1:0]            quo_reg,          quo_next;
    logic [IDX_W-1:0]         div_rem_reg,      div_rem_next;
    logic                     neg_reg,          neg_next;

    // per-lane step (dq, dr) and running quotient/remainder
    logic [QW-1:0]            dq_reg [NCH];
    logic [QW-1:0]            dq_next [NCH];
    logic [IDX_W-1:0]         dr_reg [NCH];
    logic [IDX_W-1:0]         dr_next [NCH];
    logic [QW-1:0]            q_reg [NCH];
    logic [QW-1:0]            q_next [NCH];
    logic [IDX_W-1:0]         rr_reg [NCH];
    logic [IDX_W-1:0]         rr_next [NCH];

    // output register
    logic                     out_valid_reg,    out_valid_next;
    logic                     out_load;
    logic [OUT_IDX_W-1:0]     out_idx_reg,      out_idx_next;
    crtg_pkg::color_t         out_col_reg [NCH];
    crtg_pkg::color_t         out_col_next [NCH];
    logic                     out_end_reg,      out_end_next;
    crtg_pkg::status_t        out_status_reg,   out_status_next;

    // ------------------------------------------------------- combinational
    logic                     slot_free;
    logic                     node_acc;
    logic [PW-1:0]            pos_sat;
    logic                     pos_is_zero;
    logic                     pos_is_one;
    logic [NERR-1:0]          chk_mask;

    logic                     ts_too_big;
    logic [TS_W-1:0]          ts_eff;
    logic [TS_W-1:0]          ts_m1;
    logic [PW+TS_W-1:0]       prod;
    logic [IDX_W-1:0]         p2_calc;
    logic [IDX_W-1:0]         p1_calc;
    logic [IDX_W-1:0]         len_calc;

    logic [CH_W-1:0]          load_ch;
    crtg_pkg::color_t         ld_c1;
    crtg_pkg::color_t         ld_c2;
    logic                     ld_neg;
    logic [CW-1:0]            ld_abs;

    logic [IDX_W:0]           trial;
    logic                     trial_ge;
    logic [IDX_W-1:0]         rem_n;
    logic [CW-1:0]            quo_n;
    logic [QW-1:0]            q_ext;
    logic                     rem_zero;
    logic [QW-1:0]            dq_val;
    logic [IDX_W-1:0]         dr_val;

    logic [IDX_W:0]           r_sum;
    logic                     r_wrap;
    logic [NERR-1:0]          err_left;
    crtg_pkg::status_t        err_code;

    assign slot_free = !out_valid_reg || texel.ready;
    assign node.ready = (state_reg == S_IDLE);
    assign node_acc = node.valid && node.ready;

    assign pos_sat     = (node.position > crtg_pkg::POS_ONE) ? crtg_pkg::POS_ONE
                                                              : node.position;
    assign pos_is_zero = (pos_sat == '0);
    assign pos_is_one  = (pos_sat == crtg_pkg::POS_ONE);

    // effective texture size and the run of the pending node
    assign ts_too_big = (int'(texture_size_reg) > MAX_TEXELS);
    assign ts_eff     = ts_too_big ? TS_W'(MAX_TEXELS)
                      : (texture_size_reg == '0) ? TS_W'(1)
                      : TS_W'(texture_size_reg);
    assign ts_m1      = ts_eff - TS_W'(1);
    assign prod       = {{TS_W{1'b0}}, new_pos_reg} * {{PW{1'b0}}, ts_m1};
    assign p2_calc    = IDX_W'(prod >> crtg_pkg::POS_FRAC_W);
    assign p1_calc    = (prev_texel_reg < p2_calc) ? prev_texel_reg : p2_calc;
    assign len_calc   = p2_calc - p1_calc;

    // divider operand for the channel being loaded
    assign load_ch = (state_reg == S_SETUP) ? '0 : ch_reg + CH_W'(1);
    assign ld_c1   = prev_col_reg[load_ch];
    assign ld_c2   = new_col_reg[load_ch];
    assign ld_neg  = (ld_c2 < ld_c1);
    assign ld_abs  = ld_neg ? (ld_c1 - ld_c2) : (ld_c2 - ld_c1);

    // one restoring step; turn |d|/L into floor-division step on the last bit
    assign trial    = {div_rem_reg, dvd_reg[CW-1]};
    assign trial_ge = (trial >= {1'b0, len_reg});
    assign rem_n    = trial_ge ? IDX_W'(trial - {1'b0, len_reg}) : trial[IDX_W-1:0];
    assign quo_n    = {quo_reg[CW-2:0], trial_ge};
    assign q_ext    = {2'b00, quo_n};
    assign rem_zero = (rem_n == '0);
    assign dq_val   = !neg_reg ? q_ext : (rem_zero ? (~q_ext + QW'(1)) : ~q_ext);
    assign dr_val   = (!neg_reg || rem_zero) ? rem_n : (len_reg - rem_n);

    // lowest pending error code goes out first
    always_comb
    begin
        err_code = crtg_pkg::ST_NO_RAMP;
        if (err_mask_reg[crtg_pkg::ST_FIRST_NOT_ZERO - 1])
        begin
            err_code = crtg_pkg::ST_FIRST_NOT_ZERO;
        end
        else if (err_mask_reg[crtg_pkg::ST_NOT_INCREASING - 1])
        begin
            err_code = crtg_pkg::ST_NOT_INCREASING;
        end
        else if (err_mask_reg[crtg_pkg::ST_LAST_NOT_ONE - 1])
        begin
            err_code = crtg_pkg::ST_LAST_NOT_ONE;
        end
        else if (err_mask_reg[crtg_pkg::ST_TOO_FEW - 1])
        begin
            err_code = crtg_pkg::ST_TOO_FEW;
        end
        err_left = err_mask_reg;
        err_left[err_code - 1] = 1'b0;
    end

    always_comb
    begin
        state_next      = state_reg;
        ramp_open_next  = ramp_open_reg;
        err_mask_next   = err_mask_reg;
        prev_pos_next   = prev_pos_reg;
        prev_texel_next = prev_texel_reg;
        new_pos_next    = new_pos_reg;
        new_last_next   = new_last_reg;
        p1_next         = p1_reg;
        p2_next         = p2_reg;
        len_next        = len_reg;
        k_next          = k_reg;
        ch_next         = ch_reg;
        bit_next        = bit_reg;
        dvd_next        = dvd_reg;
        quo_next        = quo_reg;
        div_rem_next    = div_rem_reg;
        neg_next        = neg_reg;
        out_load        = 1'b0;
        out_idx_next    = out_idx_reg;
        out_end_next    = out_end_reg;
        out_status_next = out_status_reg;
        chk_mask        = '0;
        r_sum           = '0;
        r_wrap          = 1'b0;
        for (int i = 0; i < NCH; i++)
        begin
            prev_col_next[i] = prev_col_reg[i];
            new_col_next[i]  = new_col_reg[i];
            dq_next[i]       = dq_reg[i];
            dr_next[i]       = dr_reg[i];
            q_next[i]        = q_reg[i];
            rr_next[i]       = rr_reg[i];
            out_col_next[i]  = out_col_reg[i];
        end

        if (out_valid_reg && texel.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (node_acc)
                begin
                    if (node.first_node)
                    begin
                        chk_mask[crtg_pkg::ST_FIRST_NOT_ZERO - 1] = !pos_is_zero;
                        chk_mask[crtg_pkg::ST_LAST_NOT_ONE - 1] =
                            node.last_node && !pos_is_one;
                        chk_mask[crtg_pkg::ST_TOO_FEW - 1] = node.last_node;
                        if (chk_mask != '0)
                        begin
                            err_mask_next  = chk_mask;
                            ramp_open_next = 1'b0;
                            state_next     = S_ERR;
                        end
                        else
                        begin
                            prev_col_next[0] = node.red;
                            prev_col_next[1] = node.green;
                            prev_col_next[2] = node.blue;
                            prev_col_next[3] = node.opacity;
                            prev_pos_next    = pos_sat;
                            prev_texel_next  = '0;
                            ramp_open_next   = 1'b1;
                        end
                    end
                    else if (!ramp_open_reg)
                    begin
                        chk_mask[crtg_pkg::ST_NO_RAMP - 1] = 1'b1;
                        err_mask_next = chk_mask;
                        state_next    = S_ERR;
                    end
                    else
                    begin
                        chk_mask[crtg_pkg::ST_NOT_INCREASING - 1] = (pos_sat <= prev_pos_reg);
                        chk_mask[crtg_pkg::ST_LAST_NOT_ONE - 1] =
                            node.last_node && !pos_is_one;
                        if (chk_mask != '0)
                        begin
                            err_mask_next  = chk_mask;
                            ramp_open_next = 1'b0;
                            state_next     = S_ERR;
                        end
                        else
                        begin
                            new_col_next[0] = node.red;
                            new_col_next[1] = node.green;
                            new_col_next[2] = node.blue;
                            new_col_next[3] = node.opacity;
                            new_pos_next    = pos_sat;
                            new_last_next   = node.last_node;
                            state_next      = S_SETUP;
                        end
                    end
                end
            end

            S_SETUP:
            begin
                p1_next  = p1_calc;
                p2_next  = p2_calc;
                len_next = len_calc;
                k_next   = '0;
                for (int i = 0; i < NCH; i++)
                begin
                    q_next[i]  = (len_calc == '0) ? QW'(new_col_reg[i])
                                                  : QW'(prev_col_reg[i]);
                    rr_next[i] = '0;
                end
                if (len_calc == '0)
                begin
                    state_next = S_RUN;
                end
                else
                begin
                    ch_next      = '0;
                    bit_next     = '0;
                    dvd_next     = ld_abs;
                    neg_next     = ld_neg;
                    quo_next     = '0;
                    div_rem_next = '0;
                    state_next   = S_DIV;
                end
            end

            S_DIV:
            begin
                dvd_next     = {dvd_reg[CW-2:0], 1'b0};
                quo_next     = quo_n;
                div_rem_next = rem_n;
                bit_next     = bit_reg + BIT_W'(1);
                if (bit_reg == BIT_W'(CW - 1))
                begin
                    dq_next[ch_reg] = dq_val;
                    dr_next[ch_reg] = dr_val;
                    if (ch_reg == CH_W'(NCH - 1))
                    begin
                        state_next = S_RUN;
                    end
                    else
                    begin
                        ch_next      = ch_reg + CH_W'(1);
                        dvd_next     = ld_abs;
                        neg_next     = ld_neg;
                        quo_next     = '0;
                        div_rem_next = '0;
                    end
                end
            end

            S_RUN:
            begin
                if (slot_free)
                begin
                    out_load        = 1'b1;
                    out_valid_next  = 1'b1;
                    out_idx_next    = OUT_IDX_W'(p1_reg + k_reg);
                    out_end_next    = (k_reg == len_reg);
                    out_status_next = crtg_pkg::ST_OK;
                    for (int i = 0; i < NCH; i++)
                    begin
                        out_col_next[i] = q_reg[i][CW-1:0];
                    end
                    if (k_reg == len_reg)
                    begin
                        for (int i = 0; i < NCH; i++)
                        begin
                            prev_col_next[i] = new_col_reg[i];
                        end
                        prev_pos_next   = new_pos_reg;
                        prev_texel_next = p2_reg;
                        if (new_last_reg)
                        begin
                            ramp_open_next = 1'b0;
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + IDX_W'(1);
                        for (int i = 0; i < NCH; i++)
                        begin
                            r_sum      = {1'b0, rr_reg[i]} + {1'b0, dr_reg[i]};
                            r_wrap     = (r_sum >= {1'b0, len_reg});
                            rr_next[i] = r_wrap ? IDX_W'(r_sum - {1'b0, len_reg})
                                                : r_sum[IDX_W-1:0];
                            q_next[i]  = q_reg[i] + dq_reg[i] + QW'(r_wrap);
                        end
                    end
                end
            end

            S_ERR:
            begin
                if (slot_free)
                begin
                    out_load        = 1'b1;
                    out_valid_next  = 1'b1;
                    out_idx_next    = '0;
                    out_end_next    = (err_left == '0);
                    out_status_next = err_code;
                    for (int i = 0; i < NCH; i++)
                    begin
                        out_col_next[i] = '0;
                    end
                    err_mask_next = err_left;
                    if (err_left == '0)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            texture_size_reg <= crtg_pkg::TSIZE_RESET;
            ramp_open_reg    <= 1'b0;
            err_mask_reg     <= '0;
            prev_pos_reg     <= '0;
            prev_texel_reg   <= '0;
            out_valid_reg    <= 1'b0;
            k_reg            <= '0;
            ch_reg           <= '0;
            bit_reg          <= '0;
            for (int i = 0; i < NCH; i++)
            begin
                prev_col_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            ramp_open_reg  <= ramp_open_next;
            err_mask_reg   <= err_mask_next;
            prev_pos_reg   <= prev_pos_next;
            prev_texel_reg <= prev_texel_next;
            out_valid_reg  <= out_valid_next;
            k_reg          <= k_next;
            ch_reg         <= ch_next;
            bit_reg        <= bit_next;
            for (int i = 0; i < NCH; i++)
            begin
                prev_col_reg[i] <= prev_col_next[i];
            end
            if (cfg_we)
            begin
                texture_size_reg <= cfg_wdata;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        new_pos_reg  <= new_pos_next;
        new_last_reg <= new_last_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        len_reg      <= len_next;
        dvd_reg      <= dvd_next;
        quo_reg      <= quo_next;
        div_rem_reg  <= div_rem_next;
        neg_reg      <= neg_next;
        for (int i = 0; i < NCH; i++)
        begin
            new_col_reg[i] <= new_col_next[i];
            dq_reg[i]      <= dq_next[i];
            dr_reg[i]      <= dr_next[i];
            q_reg[i]       <= q_next[i];
            rr_reg[i]      <= rr_next[i];
        end
        if (out_load)
        begin
            out_idx_reg    <= out_idx_next;
            out_end_reg    <= out_end_next;
            out_status_reg <= out_status_next;
            for (int i = 0; i < NCH; i++)
            begin
                out_col_reg[i] <= out_col_next[i];
            end
        end
    end

    assign texel.valid         = out_valid_reg;
    assign texel.texel_index   = out_idx_reg;
    assign texel.texel_red     = out_col_reg[0];
    assign texel.texel_green   = out_col_reg[1];
    assign texel.texel_blue    = out_col_reg[2];
    assign texel.texel_opacity = out_col_reg[3];
    assign texel.end_of_run    = out_end_reg;
    assign texel.status        = out_status_reg;

    // ---------------------------------------------------------- assertions
`include "color_ramp_texture_generator_unit_assert.svh"

    `CRTG_ASSERT_IMPL(a_div_rem_below_len, state_reg == S_DIV, div_rem_reg < len_reg)
    `CRTG_ASSERT_IMPL(a_run_k_in_range, state_reg == S_RUN, k_reg <= len_reg)
    `CRTG_ASSERT_IMPL(a_err_pending, state_reg == S_ERR, err_mask_reg != '0)
    `CRTG_ASSERT_IMPL(a_step_rem_below_len, (state_reg == S_RUN) && (len_reg != '0),
        rr_reg[0] < len_reg)
    `CRTG_ASSERT_NEXT(a_no_ramp_error, node_acc && !node.first_node && !ramp_open_reg,
        (state_reg == S_ERR) && $onehot(err_mask_reg)
        && err_mask_reg[crtg_pkg::ST_NO_RAMP - 1])

endmodule
